// File: sv/dbfs_pkg.sv
// dbfs_pkg: shared constants, command codes and controller/datapath structs
// for the double-buffered LED frame store; depends on nothing
`default_nettype none

package dbfs_pkg;

    localparam int STRING_COUNT_DEF    = 4;
    localparam int LEDS_PER_STRING_DEF = 10;
    localparam int BANK_SIZE_DEF       = 5;

    localparam int COLOR_W     = 24;
    localparam int INDEX_W     = 6;
    localparam int BANK_W      = 3;
    localparam int BANK_COLORS = 5;

    localparam logic [INDEX_W-1:0] MAX_BANK = 6'd7;

    typedef enum logic [2:0] {
        CMD_BANK_SELECT = 3'd0,
        CMD_BANK_WRITE  = 3'd1,
        CMD_LED_SELECT  = 3'd2,
        CMD_LED_WRITE   = 3'd3,
        CMD_FILL        = 3'd4,
        CMD_CLEAR       = 3'd5,
        CMD_REFRESH     = 3'd6,
        CMD_TICK        = 3'd7
    } t_cmd;

    typedef struct packed {
        logic init;
        logic accept;
        logic bank;
        logic fill;
        logic copy;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic init_last;
        logic bank_last;
        logic fill_last;
        logic copy_done;
        logic emit_done;
        logic bank_armed;
        logic copy_pending;
    } t_status;

endpackage

`default_nettype wire

// File: sv/dbfs_ram.sv
// dbfs_ram: generic single-write, single-read RAM with registered read data
// standalone, no package dependency
`default_nettype none

module dbfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/dbfs_ctrl.sv
// dbfs_ctrl: command sequencer for the frame store (clear pass, sweeps, emission)
// depends on dbfs_pkg
`default_nettype none

module dbfs_ctrl
    import dbfs_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [2:0]    i_command,
    input  wire t_status       i_status,
    output logic               o_ready,
    output t_ctl               o_ctl
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_BANK = 6'b000100,
        S_FILL = 6'b001000,
        S_COPY = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command)) inside
                        CMD_BANK_WRITE: begin
                            if (i_status.bank_armed) n_state = S_BANK;
                        end
                        CMD_FILL, CMD_CLEAR: begin
                            n_state = S_FILL;
                        end
                        CMD_TICK: begin
                            n_state = i_status.copy_pending ? S_COPY : S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_BANK: begin
                if (i_status.bank_last) n_state = S_IDLE;
            end
            S_FILL: begin
                if (i_status.fill_last) n_state = S_IDLE;
            end
            S_COPY: begin
                if (i_status.copy_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.emit_done) n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_ctl.init    = (r_state == S_INIT);
    assign o_ctl.accept  = accept;
    assign o_ctl.bank    = (r_state == S_BANK);
    assign o_ctl.fill    = (r_state == S_FILL);
    assign o_ctl.copy    = (r_state == S_COPY);
    assign o_ctl.emit    = (r_state == S_EMIT);

endmodule

`default_nettype wire

// File: sv/dbfs_datapath.sv
// dbfs_datapath: shadow and active pixel RAMs, host registers, sweep counter
// and the two-stage pixel output pipe; depends on dbfs_pkg and dbfs_ram
`default_nettype none

module dbfs_datapath
    import dbfs_pkg::*;
#(
    parameter int STRING_COUNT    = STRING_COUNT_DEF,
    parameter int LEDS_PER_STRING = LEDS_PER_STRING_DEF,
    parameter int BANK_SIZE       = BANK_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctl               i_ctl,
    input  wire logic [2:0]         i_command,
    input  wire logic [INDEX_W-1:0] i_index,
    input  wire logic [COLOR_W-1:0] i_color0,
    input  wire logic [COLOR_W-1:0] i_color1,
    input  wire logic [COLOR_W-1:0] i_color2,
    input  wire logic [COLOR_W-1:0] i_color3,
    input  wire logic [COLOR_W-1:0] i_color4,
    input  wire logic               i_ready,
    output t_status                 o_status,
    output logic                    o_valid,
    output logic [1:0]              o_string_number,
    output logic [3:0]              o_position,
    output logic [7:0]              o_hue,
    output logic [7:0]              o_saturation,
    output logic [7:0]              o_brightness,
    output logic                    o_last
);

    localparam int PIXEL_COUNT = STRING_COUNT * LEDS_PER_STRING;
    localparam int BANK_WRITES = (BANK_SIZE < BANK_COLORS) ? BANK_SIZE : BANK_COLORS;
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_MAX = (PIXEL_COUNT > BANK_WRITES) ? PIXEL_COUNT : BANK_WRITES;
    localparam int CW = $clog2(CNT_MAX + 1);
    localparam int SW = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;
    localparam int PW = (LEDS_PER_STRING > 1) ? $clog2(LEDS_PER_STRING) : 1;

    // host registers
    logic [INDEX_W-1:0] r_pixel_index;
    logic [BANK_W-1:0]  r_bank_number;
    logic               r_bank_armed;
    logic               r_led_armed;
    logic               r_copy_pending;
    logic [COLOR_W-1:0] r_fill;
    logic [COLOR_W-1:0] r_bank_col [BANK_COLORS];

    logic [CW-1:0]      r_cnt;
    logic               r_copy_vld;
    logic [AW-1:0]      r_copy_addr;

    // emission
    logic [SW-1:0]      r_estr;
    logic [PW-1:0]      r_epos;
    logic [AW-1:0]      r_eaddr;
    logic               r_all_issued;
    logic               r_s1_vld;
    logic [SW-1:0]      r_s1_str;
    logic [PW-1:0]      r_s1_pos;
    logic               r_s1_last;
    logic               r_o_vld;
    logic [1:0]         r_o_str;
    logic [3:0]         r_o_pos;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_last;

    logic               sh_we;
    logic [AW-1:0]      sh_waddr;
    logic [COLOR_W-1:0] sh_wdata;
    logic               sh_re;
    logic [COLOR_W-1:0] sh_rdata;
    logic               ac_we;
    logic [AW-1:0]      ac_waddr;
    logic [COLOR_W-1:0] ac_wdata;
    logic [COLOR_W-1:0] ac_rdata;

    logic               sweep;
    logic [6:0]         bank_addr;
    logic               bank_in_range;
    logic               led_in_range;
    logic               cnt_in_range;
    logic               s1_move;
    logic               issue;
    logic               issue_last;
    logic               estr_end;
    t_cmd               cmd;

    assign cmd           = t_cmd'(i_command);
    assign sweep         = i_ctl.init || i_ctl.bank || i_ctl.fill || i_ctl.copy;
    assign bank_addr     = 7'(r_pixel_index) + 7'(r_cnt);
    assign bank_in_range = 32'(bank_addr) < PIXEL_COUNT;
    assign led_in_range  = 32'(r_pixel_index) < PIXEL_COUNT;
    assign cnt_in_range  = 32'(r_cnt) < PIXEL_COUNT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_index  <= '0;
            r_bank_number  <= '0;
            r_bank_armed   <= 1'b0;
            r_led_armed    <= 1'b0;
            r_copy_pending <= 1'b0;
        end else if (i_ctl.accept) begin
            unique case (cmd)
                CMD_BANK_SELECT: begin
                    if (i_index <= MAX_BANK) begin
                        r_bank_number <= i_index[BANK_W-1:0];
                        r_bank_armed  <= 1'b1;
                    end
                end
                CMD_BANK_WRITE: begin
                    if (r_bank_armed) begin
                        r_bank_armed  <= 1'b0;
                        r_pixel_index <= INDEX_W'(32'(r_bank_number) * BANK_SIZE);
                    end
                end
                CMD_LED_SELECT: begin
                    if (32'(i_index) < PIXEL_COUNT) begin
                        r_pixel_index <= i_index;
                        r_led_armed   <= 1'b1;
                    end
                end
                CMD_LED_WRITE: begin
                    r_led_armed <= 1'b0;
                end
                CMD_REFRESH: begin
                    r_copy_pending <= 1'b1;
                end
                CMD_TICK: begin
                    r_copy_pending <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // colour latches for fill/clear and the bank write shift line
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_fill        <= (cmd == CMD_FILL) ? i_color0 : '0;
            r_bank_col[0] <= i_color0;
            r_bank_col[1] <= i_color1;
            r_bank_col[2] <= i_color2;
            r_bank_col[3] <= i_color3;
            r_bank_col[4] <= i_color4;
        end else if (i_ctl.bank) begin
            for (int i = 0; i < BANK_COLORS - 1; i++) begin
                r_bank_col[i] <= r_bank_col[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_copy_vld <= 1'b0;
        end else begin
            r_cnt      <= sweep ? r_cnt + CW'(1) : '0;
            r_copy_vld <= i_ctl.copy && cnt_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy_addr <= r_cnt[AW-1:0];
    end

    // shadow write port: clear pass, led write, bank write
    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = r_cnt[AW-1:0];
        sh_wdata = '0;
        if (i_ctl.init) begin
            sh_we = 1'b1;
        end else if (i_ctl.bank) begin
            sh_we    = bank_in_range;
            sh_waddr = AW'(bank_addr);
            sh_wdata = r_bank_col[0];
        end else if (i_ctl.accept && cmd == CMD_LED_WRITE) begin
            sh_we    = r_led_armed && led_in_range;
            sh_waddr = AW'(r_pixel_index);
            sh_wdata = i_color0;
        end
    end

    assign sh_re = i_ctl.copy && cnt_in_range;

    // active write port: clear pass, fill/clear sweep, copy
    always_comb begin
        ac_we    = 1'b0;
        ac_waddr = r_cnt[AW-1:0];
        ac_wdata = '0;
        if (i_ctl.init) begin
            ac_we = 1'b1;
        end else if (i_ctl.fill) begin
            ac_we    = 1'b1;
            ac_wdata = r_fill;
        end else if (r_copy_vld) begin
            ac_we    = 1'b1;
            ac_waddr = r_copy_addr;
            ac_wdata = sh_rdata;
        end
    end

    dbfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXEL_COUNT)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (sh_waddr),
        .i_wdata (sh_wdata),
        .i_re    (sh_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (sh_rdata)
    );

    dbfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXEL_COUNT)
    ) u_active (
        .i_clk   (i_clk),
        .i_we    (ac_we),
        .i_waddr (ac_waddr),
        .i_wdata (ac_wdata),
        .i_re    (issue),
        .i_raddr (r_eaddr),
        .o_rdata (ac_rdata)
    );

    // emission: read stage (ram output) then output register
    assign s1_move    = r_s1_vld && (!r_o_vld || i_ready);
    assign issue      = i_ctl.emit && !r_all_issued && (!r_s1_vld || s1_move);
    assign estr_end   = (r_estr == SW'(STRING_COUNT - 1));
    assign issue_last = estr_end && (r_epos == PW'(LEDS_PER_STRING - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estr       <= '0;
            r_epos       <= '0;
            r_eaddr      <= '0;
            r_all_issued <= 1'b0;
        end else if (!i_ctl.emit) begin
            r_estr       <= '0;
            r_epos       <= '0;
            r_eaddr      <= '0;
            r_all_issued <= 1'b0;
        end else if (issue) begin
            if (issue_last) begin
                r_all_issued <= 1'b1;
            end
            if (estr_end) begin
                r_estr  <= '0;
                r_epos  <= r_epos + PW'(1);
                r_eaddr <= AW'(r_epos) + AW'(1);
            end else begin
                r_estr  <= r_estr + SW'(1);
                r_eaddr <= r_eaddr + AW'(LEDS_PER_STRING);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (!r_o_vld || i_ready) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_str  <= r_estr;
            r_s1_pos  <= r_epos;
            r_s1_last <= issue_last;
        end
        if (s1_move) begin
            r_o_str   <= 2'(r_s1_str);
            r_o_pos   <= 4'(r_s1_pos);
            r_o_color <= ac_rdata;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_string_number = r_o_str;
    assign o_position      = r_o_pos;
    assign o_hue           = r_o_color[23:16];
    assign o_saturation    = r_o_color[15:8];
    assign o_brightness    = r_o_color[7:0];
    assign o_last          = r_o_last;

    assign o_status.init_last    = i_ctl.init && (r_cnt == CW'(PIXEL_COUNT - 1));
    assign o_status.bank_last    = i_ctl.bank && (r_cnt == CW'(BANK_WRITES - 1));
    assign o_status.fill_last    = i_ctl.fill && (r_cnt == CW'(PIXEL_COUNT - 1));
    assign o_status.copy_done    = i_ctl.copy && (r_cnt == CW'(PIXEL_COUNT));
    assign o_status.emit_done    = r_o_vld && i_ready && r_o_last;
    assign o_status.bank_armed   = r_bank_armed;
    assign o_status.copy_pending = r_copy_pending;

endmodule

`default_nettype wire

// File: sv/double_buffered_led_frame_store_core.sv
// double_buffered_led_frame_store_core: top level of the LED frame store
// depends on dbfs_pkg, dbfs_ctrl, dbfs_datapath (and dbfs_ram below it)
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  command   | i_valid / o_ready  | i_command, i_index, i_color0 .. i_color4
//  pixel     | o_valid / i_ready  | o_string_number, o_position, o_hue,
//            |                    | o_saturation, o_brightness, o_last
//
// select, led write and refresh items complete when accepted; an armed bank write
// writes min(BANK_SIZE,5) pixels and fill/clear sweep PIXEL_COUNT pixels (one ram write port)
// a tick first copies the shadow ram into the active ram when a copy is
// pending, then emits one pixel per cycle from the active ram read port while i_ready is high
// after reset a clearing pass of PIXEL_COUNT pixels (40 by default) runs before o_ready rises
// a stalled i_ready holds the pixel pipe; o_ready stays low until the last pixel is taken
`default_nettype none

module double_buffered_led_frame_store_core
    import dbfs_pkg::*;
#(
    parameter int STRING_COUNT    = STRING_COUNT_DEF,
    parameter int LEDS_PER_STRING = LEDS_PER_STRING_DEF,
    parameter int BANK_SIZE       = BANK_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic [INDEX_W-1:0] i_index,
    input  wire logic [COLOR_W-1:0] i_color0,
    input  wire logic [COLOR_W-1:0] i_color1,
    input  wire logic [COLOR_W-1:0] i_color2,
    input  wire logic [COLOR_W-1:0] i_color3,
    input  wire logic [COLOR_W-1:0] i_color4,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_string_number,
    output logic [3:0]              o_position,
    output logic [7:0]              o_hue,
    output logic [7:0]              o_saturation,
    output logic [7:0]              o_brightness,
    output logic                    o_last
);

    t_ctl    ctl;
    t_status status;

    dbfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_status  (status),
        .o_ready   (o_ready),
        .o_ctl     (ctl)
    );

    dbfs_datapath #(
        .STRING_COUNT    (STRING_COUNT),
        .LEDS_PER_STRING (LEDS_PER_STRING),
        .BANK_SIZE       (BANK_SIZE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_command       (i_command),
        .i_index         (i_index),
        .i_color0        (i_color0),
        .i_color1        (i_color1),
        .i_color2        (i_color2),
        .i_color3        (i_color3),
        .i_color4        (i_color4),
        .i_ready         (i_ready),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_string_number (o_string_number),
        .o_position      (o_position),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_brightness    (o_brightness),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking testbench for the double-buffered led frame store core
// drives command items, predicts every emitted pixel and compares field by field
// depends on dbfs_pkg and double_buffered_led_frame_store_core
module tb_top
    import dbfs_pkg::*;
();

    localparam int NSTR    = STRING_COUNT_DEF;
    localparam int NPOS    = LEDS_PER_STRING_DEF;
    localparam int NPIX    = NSTR * NPOS;
    localparam int N_RAND  = 255;
    localparam logic [23:0] WHITE = 24'hFFFFFF;

    typedef struct packed {
        t_cmd             cmd;
        logic [5:0]       idx;
        logic [4:0][23:0] col;
        logic             chk;
        logic [23:0]      chk_col;
    } t_cmd_row;

    typedef struct packed {
        logic [1:0] str;
        logic [3:0] pos;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] bri;
        logic       last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_command;
    logic [5:0]  i_index;
    logic [23:0] i_color0, i_color1, i_color2, i_color3, i_color4;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_string_number;
    logic [3:0]  o_position;
    logic [7:0]  o_hue, o_saturation, o_brightness;
    logic        o_last;

    double_buffered_led_frame_store_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_index         (i_index),
        .i_color0        (i_color0),
        .i_color1        (i_color1),
        .i_color2        (i_color2),
        .i_color3        (i_color3),
        .i_color4        (i_color4),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_string_number (o_string_number),
        .o_position      (o_position),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_brightness    (o_brightness),
        .o_last          (o_last)
    );

    // predicted frame store state
    logic [23:0] shadow_q [NPIX];
    logic [23:0] active_q [NPIX];
    logic [5:0]  led_ptr;
    logic [2:0]  bank_sel;
    logic        bank_arm;
    logic        led_arm;
    logic        copy_due;

    t_pixel   pixel_exp_q [$];
    t_cmd_row directed_q [$];
    int       errs = 0;
    int       items_sent;
    int       ticks_sent;
    int       pixels_checked = 0;
    int       burst_left;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_cmd_row row(t_cmd c, logic [5:0] ix, logic [23:0] c0,
                                     logic [23:0] c1, logic [23:0] c2, logic [23:0] c3,
                                     logic [23:0] c4, logic ck, logic [23:0] ckc);
        t_cmd_row r;
        r.cmd     = c;
        r.idx     = ix;
        r.col[0]  = c0;
        r.col[1]  = c1;
        r.col[2]  = c2;
        r.col[3]  = c3;
        r.col[4]  = c4;
        r.chk     = ck;
        r.chk_col = ckc;
        return r;
    endfunction

    function automatic logic [23:0] rnd_color();
        int w;
        w = $urandom_range(0, 15);
        if (w == 0) return 24'h000000;
        if (w == 1) return WHITE;
        return 24'($urandom);
    endfunction

    function automatic t_cmd_row rnd_row(t_cmd c, logic [5:0] ix);
        return row(c, ix, rnd_color(), rnd_color(), rnd_color(), rnd_color(), rnd_color(),
                   1'b0, 24'h0);
    endfunction

    function automatic void reset_frame_store();
        for (int p = 0; p < NPIX; p++) begin
            shadow_q[p] = '0;
            active_q[p] = '0;
        end
        led_ptr  = '0;
        bank_sel = '0;
        bank_arm = 1'b0;
        led_arm  = 1'b0;
        copy_due = 1'b0;
    endfunction

    function automatic void advance_frame_store(t_cmd_row r);
        t_pixel      px;
        logic [23:0] c;
        int          n;
        n = 0;
        case (r.cmd)
            CMD_BANK_SELECT: begin
                if (r.idx <= MAX_BANK) begin
                    bank_sel = r.idx[2:0];
                    bank_arm = 1'b1;
                end
            end
            CMD_BANK_WRITE: begin
                if (bank_arm) begin
                    bank_arm = 1'b0;
                    led_ptr  = 6'(int'(bank_sel) * BANK_SIZE_DEF);
                    for (int k = 0; k < BANK_SIZE_DEF && k < BANK_COLORS; k++) begin
                        if (int'(led_ptr) + k < NPIX) shadow_q[int'(led_ptr) + k] = r.col[k];
                    end
                end
            end
            CMD_LED_SELECT: begin
                if (int'(r.idx) < NPIX) begin
                    led_ptr = r.idx;
                    led_arm = 1'b1;
                end
            end
            CMD_LED_WRITE: begin
                if (led_arm) begin
                    led_arm = 1'b0;
                    if (int'(led_ptr) < NPIX) shadow_q[led_ptr] = r.col[0];
                end
            end
            CMD_FILL: begin
                for (int p = 0; p < NPIX; p++) active_q[p] = r.col[0];
            end
            CMD_CLEAR: begin
                for (int p = 0; p < NPIX; p++) active_q[p] = '0;
            end
            CMD_REFRESH: begin
                copy_due = 1'b1;
            end
            default: begin
                if (copy_due) begin
                    for (int p = 0; p < NPIX; p++) active_q[p] = shadow_q[p];
                    copy_due = 1'b0;
                end
                for (int pos = 0; pos < NPOS; pos++) begin
                    for (int s = 0; s < NSTR; s++) begin
                        c = r.chk ? r.chk_col : active_q[s * NPOS + pos];
                        n++;
                        px.str  = 2'(s);
                        px.pos  = 4'(pos);
                        px.hue  = c[23:16];
                        px.sat  = c[15:8];
                        px.bri  = c[7:0];
                        px.last = (n == NPIX);
                        pixel_exp_q.push_back(px);
                    end
                end
            end
        endcase
    endfunction

    task automatic send_item(input t_cmd_row r);
        i_valid   <= 1'b1;
        i_command <= r.cmd;
        i_index   <= r.idx;
        i_color0  <= r.col[0];
        i_color1  <= r.col[1];
        i_color2  <= r.col[2];
        i_color3  <= r.col[3];
        i_color4  <= r.col[4];
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        advance_frame_store(r);
        items_sent++;
        if (r.cmd == CMD_TICK) ticks_sent++;
    endtask

    // called in the step an item was taken; decides the next gap
    task automatic pace_sender(input bit drain);
        if (drain) begin
            i_valid <= 1'b0;
            while (pixel_exp_q.size() != 0) @(posedge i_clk);
            repeat (100) @(posedge i_clk);
        end else if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic build_random_group(ref t_cmd_row q [$]);
        int w;
        w = $urandom_range(0, 99);
        if (w < 22) begin
            q.push_back(rnd_row(CMD_BANK_SELECT, 6'($urandom_range(0, 7))));
            q.push_back(rnd_row(CMD_BANK_WRITE, 6'($urandom_range(0, 63))));
        end else if (w < 42) begin
            q.push_back(rnd_row(CMD_LED_SELECT, 6'($urandom_range(0, NPIX - 1))));
            q.push_back(rnd_row(CMD_LED_WRITE, 6'($urandom_range(0, 63))));
        end else if (w < 47) begin
            q.push_back(rnd_row(CMD_LED_SELECT, 6'($urandom_range(0, NPIX - 1))));
            q.push_back(rnd_row(CMD_BANK_SELECT, 6'($urandom_range(0, 7))));
            q.push_back(rnd_row(CMD_BANK_WRITE, 6'($urandom_range(0, 63))));
            q.push_back(rnd_row(CMD_LED_WRITE, 6'($urandom_range(0, 63))));
        end else if (w < 54) begin
            q.push_back(rnd_row(CMD_FILL, 6'($urandom_range(0, 63))));
        end else if (w < 59) begin
            q.push_back(rnd_row(CMD_CLEAR, 6'($urandom_range(0, 63))));
        end else if (w < 70) begin
            q.push_back(rnd_row(CMD_REFRESH, 6'($urandom_range(0, 63))));
        end else if (w < 84) begin
            q.push_back(rnd_row(CMD_TICK, 6'($urandom_range(0, 63))));
        end else begin
            q.push_back(rnd_row(t_cmd'($urandom_range(0, 7)), 6'($urandom_range(0, 63))));
        end
    endtask

    initial begin
        t_cmd_row rand_q [$];
        t_cmd_row r;
        int       n_rand;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_command  <= CMD_BANK_SELECT;
        i_index    <= '0;
        i_color0   <= '0;
        i_color1   <= '0;
        i_color2   <= '0;
        i_color3   <= '0;
        i_color4   <= '0;
        items_sent = 0;
        ticks_sent = 0;
        burst_left = 0;
        reset_frame_store();

        directed_q.push_back(row(CMD_TICK, 6'd0, '0, '0, '0, '0, '0, 1'b1, 24'h000000));
        directed_q.push_back(row(CMD_FILL, 6'd63, WHITE, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_TICK, 6'd63, '0, '0, '0, '0, '0, 1'b1, WHITE));
        directed_q.push_back(row(CMD_CLEAR, 6'd0, WHITE, WHITE, WHITE, WHITE, WHITE, 1'b0,
                                 '0));
        directed_q.push_back(row(CMD_TICK, 6'd0, WHITE, '0, '0, '0, '0, 1'b1, 24'h000000));
        // out-of-range selects, then writes without arming
        directed_q.push_back(row(CMD_BANK_SELECT, 6'd8, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_WRITE, 6'd0, WHITE, WHITE, WHITE, WHITE, WHITE,
                                 1'b0, '0));
        directed_q.push_back(row(CMD_LED_SELECT, 6'd40, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_LED_WRITE, 6'd63, WHITE, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_REFRESH, 6'd0, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_TICK, 6'd0, '0, '0, '0, '0, '0, 1'b1, 24'h000000));
        directed_q.push_back(row(CMD_BANK_SELECT, 6'd7, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_WRITE, 6'd0, WHITE, 24'h000000, 24'hFF0000,
                                 24'h00FF00, 24'h0000FF, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_SELECT, 6'd0, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_WRITE, 6'd0, 24'h123456, 24'hABCDEF, 24'h800000,
                                 24'h008000, 24'h000080, 1'b0, '0));
        directed_q.push_back(row(CMD_LED_SELECT, 6'd39, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_LED_WRITE, 6'd0, 24'h5A5A5A, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_LED_SELECT, 6'd63, '0, '0, '0, '0, '0, 1'b0, '0));
        // bank write moves the led index while the led stays armed
        directed_q.push_back(row(CMD_LED_SELECT, 6'd20, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_SELECT, 6'd2, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_BANK_WRITE, 6'd0, 24'h111111, 24'h222222, 24'h333333,
                                 24'h444444, 24'h555555, 1'b0, '0));
        directed_q.push_back(row(CMD_LED_WRITE, 6'd0, 24'hA5A5A5, '0, '0, '0, '0, 1'b0, '0));
        // fill with a copy pending, the copy still wins at the tick
        directed_q.push_back(row(CMD_REFRESH, 6'd0, '0, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_FILL, 6'd0, 24'h0F0F0F, '0, '0, '0, '0, 1'b0, '0));
        directed_q.push_back(row(CMD_TICK, 6'd0, '0, '0, '0, '0, '0, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            send_item(directed_q[i]);
            pace_sender(i == directed_q.size() - 1);
        end

        n_rand = 0;
        while (n_rand < N_RAND) begin
            if (rand_q.size() == 0) build_random_group(rand_q);
            r = rand_q.pop_front();
            send_item(r);
            n_rand++;
            pace_sender(n_rand == N_RAND / 2);
        end

        i_valid <= 1'b0;
        while (pixel_exp_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("run covered %0d command items with %0d ticks and %0d pixels checked,",
                 items_sent, ticks_sent, pixels_checked);
        $display("including unarmed writes, out-of-range selects and a long output stall");
        if (errs == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver stall pattern with one long hold-off mid frame
    initial begin
        int  mode;
        int  len;
        int  taken;
        int  phase;
        bit  held;
        taken = 0;
        phase = 0;
        held  = 1'b0;
        i_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                @(posedge i_clk);
                if (o_valid === 1'b1 && i_ready === 1'b1) taken++;
                phase++;
                if (!held && taken >= 220) begin
                    held = 1'b1;
                    i_ready <= 1'b0;
                    repeat (400) @(posedge i_clk);
                end else begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        2: i_ready <= (phase % 4 != 0);
                        default: i_ready <= ($urandom_range(0, 5) == 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pixel_exp_q.size() == 0) begin
                $error("unexpected pixel: string %0d position %0d", o_string_number,
                       o_position);
                errs++;
            end else begin
                e = pixel_exp_q.pop_front();
                pixels_checked++;
                if (o_string_number !== e.str) begin
                    $error("string_number: expected %0d, got %0d", e.str, o_string_number);
                    errs++;
                end
                if (o_position !== e.pos) begin
                    $error("position: expected %0d, got %0d", e.pos, o_position);
                    errs++;
                end
                if (o_hue !== e.hue) begin
                    $error("hue: expected %0h, got %0h", e.hue, o_hue);
                    errs++;
                end
                if (o_saturation !== e.sat) begin
                    $error("saturation: expected %0h, got %0h", e.sat, o_saturation);
                    errs++;
                end
                if (o_brightness !== e.bri) begin
                    $error("brightness: expected %0h, got %0h", e.bri, o_brightness);
                    errs++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    errs++;
                end
            end
        end
    end

    initial begin
        #1000000;
        $display("timeout with %0d pixels still expected", pixel_exp_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
sv/dbfs_pkg.sv
sv/dbfs_ram.sv
sv/dbfs_ctrl.sv
sv/dbfs_datapath.sv
sv/double_buffered_led_frame_store_core.sv
tb/tb_top.sv
